// ----- hdl/dll_pkg.sv -----
// Shared constants and codes for the linked-list manager.
`default_nettype none

package dll_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LINK_W = $clog2(DEPTH + 1);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam logic [LINK_W-1:0] SENTINEL = LINK_W'(DEPTH);

   typedef enum logic [2:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_BACK  = 3'd1,
      FUNC_POP_FRONT  = 3'd2,
      FUNC_POP_BACK   = 3'd3,
      FUNC_REMOVE     = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_NOT_USE = 2'd3
   } status_type;

endpackage

`default_nettype wire

// ----- hdl/doubly_linked_list_manager.sv -----
// Top level: doubly linked list deque over a fixed node pool.
//
//   channel   direction   handshake                 payload
//   req_      in          req_valid / req_stall     func, value, handle
//   rsp_      out         rsp_valid / rsp_stall     out_value, out_handle, status,
//                                                   list_empty, node_count
//
// One request per cycle sustained while rsp_stall stays low; a request passes the input
// register then the result register, with the list update done in one pass between them.
// The lowest-free-node search over the in-use bits sets the critical path.
// Reset empties the list at once; no clearing pass is needed.
// A stalled result holds the request in the input register and stalls req_.
`default_nettype none

module doubly_linked_list_manager
   import dll_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_func,
   input  wire logic signed [31:0] req_value,
   input  wire logic [3:0]         req_handle,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_out_value,
   output logic [3:0]              rsp_out_handle,
   output logic [1:0]              rsp_status,
   output logic                    rsp_list_empty,
   output logic [4:0]              rsp_node_count
);

   // list state
   logic [31:0]       node_value_ff [DEPTH];
   logic [LINK_W-1:0] next_link_ff  [DEPTH];
   logic [LINK_W-1:0] prev_link_ff  [DEPTH];
   logic [DEPTH-1:0]  in_use_ff;
   logic [LINK_W-1:0] first_ff;
   logic [LINK_W-1:0] last_ff;
   logic [CNT_W-1:0]  occ_ff;

   logic [31:0]       node_value_in [DEPTH];
   logic [LINK_W-1:0] next_link_in  [DEPTH];
   logic [LINK_W-1:0] prev_link_in  [DEPTH];
   logic [DEPTH-1:0]  in_use_in;
   logic [LINK_W-1:0] first_in;
   logic [LINK_W-1:0] last_in;
   logic [CNT_W-1:0]  occ_in;

   // input register
   logic              s1_valid_ff;
   logic [2:0]        s1_func_ff;
   logic [31:0]       s1_value_ff;
   logic [3:0]        s1_handle_ff;

   // result register
   logic              rsp_valid_ff;
   logic [31:0]       out_value_ff;
   logic [3:0]        out_handle_ff;
   logic [1:0]        status_ff;
   logic              list_empty_ff;
   logic [CNT_W-1:0]  node_count_ff;

   logic [31:0]       res_value;
   logic [3:0]        res_handle;
   logic [1:0]        res_status;

   logic              advance;
   logic              load;
   logic              free_found;
   logic [IDX_W-1:0]  free_idx;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   // lowest free node
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   always_comb begin
      logic [LINK_W-1:0] e_link;
      logic [LINK_W-1:0] n_link;
      logic [LINK_W-1:0] p_link;
      logic [IDX_W-1:0]  e_idx;
      logic              take;

      node_value_in = node_value_ff;
      next_link_in  = next_link_ff;
      prev_link_in  = prev_link_ff;
      in_use_in     = in_use_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      occ_in        = occ_ff;
      res_value     = '0;
      res_handle    = '0;
      res_status    = ST_OK;
      take          = 1'b0;
      e_link        = SENTINEL;
      e_idx         = '0;
      n_link        = SENTINEL;
      p_link        = SENTINEL;

      unique case (s1_func_ff)
         FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
            if (!free_found) begin
               res_status = ST_FULL;
            end else begin
               node_value_in[free_idx] = s1_value_ff;
               in_use_in[free_idx]     = 1'b1;
               occ_in                  = CNT_W'(occ_ff + 1'b1);
               res_handle              = 4'(free_idx);
               if (s1_func_ff == FUNC_PUSH_FRONT) begin
                  next_link_in[free_idx] = first_ff;
                  prev_link_in[free_idx] = SENTINEL;
                  if (first_ff < SENTINEL) begin
                     prev_link_in[first_ff[IDX_W-1:0]] = LINK_W'(free_idx);
                  end else begin
                     last_in = LINK_W'(free_idx);
                  end
                  first_in = LINK_W'(free_idx);
               end else begin
                  prev_link_in[free_idx] = last_ff;
                  next_link_in[free_idx] = SENTINEL;
                  if (last_ff < SENTINEL) begin
                     next_link_in[last_ff[IDX_W-1:0]] = LINK_W'(free_idx);
                  end else begin
                     first_in = LINK_W'(free_idx);
                  end
                  last_in = LINK_W'(free_idx);
               end
            end
         end
         FUNC_POP_FRONT, FUNC_POP_BACK: begin
            e_link = (s1_func_ff == FUNC_POP_FRONT) ? first_ff : last_ff;
            if (occ_ff == '0 || e_link >= SENTINEL) begin
               res_status = ST_EMPTY;
            end else begin
               take  = 1'b1;
               e_idx = e_link[IDX_W-1:0];
            end
         end
         FUNC_REMOVE: begin
            if (32'(s1_handle_ff) >= DEPTH || !in_use_ff[IDX_W'(s1_handle_ff)]) begin
               res_status = ST_NOT_USE;
            end else begin
               take  = 1'b1;
               e_idx = IDX_W'(s1_handle_ff);
            end
         end
         default: begin
            // unused codes leave the list alone
         end
      endcase

      if (take) begin
         n_link = next_link_ff[e_idx];
         p_link = prev_link_ff[e_idx];
         if (n_link < SENTINEL) begin
            prev_link_in[n_link[IDX_W-1:0]] = p_link;
         end else begin
            last_in = p_link;
         end
         if (p_link < SENTINEL) begin
            next_link_in[p_link[IDX_W-1:0]] = n_link;
         end else begin
            first_in = n_link;
         end
         in_use_in[e_idx] = 1'b0;
         occ_in           = CNT_W'(occ_ff - 1'b1);
         res_value        = node_value_ff[e_idx];
         res_handle       = 4'(e_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         in_use_ff    <= '0;
         first_ff     <= SENTINEL;
         last_ff      <= SENTINEL;
         occ_ff       <= '0;
      end else begin
         if (load) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            in_use_ff    <= in_use_in;
            first_ff     <= first_in;
            last_ff      <= last_in;
            occ_ff       <= occ_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_func_ff   <= req_func;
         s1_value_ff  <= req_value;
         s1_handle_ff <= req_handle;
      end
      if (advance) begin
         node_value_ff <= node_value_in;
         next_link_ff  <= next_link_in;
         prev_link_ff  <= prev_link_in;
         out_value_ff  <= res_value;
         out_handle_ff <= res_handle;
         status_ff     <= res_status;
         list_empty_ff <= (occ_in == '0);
         node_count_ff <= occ_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_value  = out_value_ff;
   assign rsp_out_handle = out_handle_ff;
   assign rsp_status     = status_ff;
   assign rsp_list_empty = list_empty_ff;
   assign rsp_node_count = 5'(node_count_ff);

`ifndef SYNTH
   a_occ_matches_use: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) == $countones(in_use_ff))
      else $error("occupancy differs from in-use count");

   a_empty_ends_sentinel: assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0) |-> (first_ff == SENTINEL && last_ff == SENTINEL))
      else $error("empty list with live end links");

   a_full_status_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (rsp_node_count == 5'(DEPTH)))
      else $error("pool full reported below capacity");

   a_empty_status_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_node_count == 5'd0 && rsp_list_empty))
      else $error("list empty reported with nodes present");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb_doubly_linked_list_manager.sv -----
// Testbench for doubly_linked_list_manager: directed and random deque traffic checked against a predictor.

typedef struct {
   logic [31:0] value;
   logic [3:0]  handle;
   logic [1:0]  status;
   logic        empty;
   logic [4:0]  count;
} list_result_type;

class list_scoreboard;
   logic [31:0]                node_val [dll_pkg::DEPTH];
   logic [dll_pkg::LINK_W-1:0] nxt [dll_pkg::DEPTH];
   logic [dll_pkg::LINK_W-1:0] prv [dll_pkg::DEPTH];
   bit   [dll_pkg::DEPTH-1:0]  used;
   logic [dll_pkg::LINK_W-1:0] head_first;
   logic [dll_pkg::LINK_W-1:0] head_last;
   int unsigned                count;
   list_result_type            pending[$];
   int unsigned                errors;

   function new();
      used = '0;
      head_first = dll_pkg::SENTINEL;
      head_last = dll_pkg::SENTINEL;
      count = 0;
      errors = 0;
      for (int i = 0; i < dll_pkg::DEPTH; i++) begin
         node_val[i] = '0;
         nxt[i] = '0;
         prv[i] = '0;
      end
   endfunction

   // unlink a live node, free it and hand back its value
   function logic [31:0] unlink(int e);
      logic [dll_pkg::LINK_W-1:0] n, p;
      n = nxt[e];
      p = prv[e];
      if (n == dll_pkg::SENTINEL) head_last = p; else prv[n] = p;
      if (p == dll_pkg::SENTINEL) head_first = n; else nxt[p] = n;
      used[e] = 1'b0;
      count--;
      return node_val[e];
   endfunction

   // random live node, or any index when the list is empty
   function logic [3:0] pick_used_handle();
      int live[$];
      for (int i = 0; i < dll_pkg::DEPTH; i++)
         if (used[i]) live.push_back(i);
      if (live.size() == 0) return 4'($urandom_range(0, dll_pkg::DEPTH - 1));
      return 4'(live[$urandom_range(0, live.size() - 1)]);
   endfunction

   function void note_request(logic [2:0] func, logic [31:0] value, logic [3:0] handle);
      list_result_type r;
      int e;
      r.value = '0;
      r.handle = '0;
      r.status = dll_pkg::ST_OK;
      e = -1;
      case (func)
         dll_pkg::FUNC_PUSH_FRONT, dll_pkg::FUNC_PUSH_BACK: begin
            for (int i = dll_pkg::DEPTH - 1; i >= 0; i--)
               if (!used[i]) e = i;
            if (e < 0) begin
               r.status = dll_pkg::ST_FULL;
            end else begin
               node_val[e] = value;
               used[e] = 1'b1;
               count++;
               if (func == dll_pkg::FUNC_PUSH_FRONT) begin
                  nxt[e] = head_first;
                  prv[e] = dll_pkg::SENTINEL;
                  if (head_first == dll_pkg::SENTINEL) head_last = dll_pkg::LINK_W'(e);
                  else prv[head_first] = dll_pkg::LINK_W'(e);
                  head_first = dll_pkg::LINK_W'(e);
               end else begin
                  prv[e] = head_last;
                  nxt[e] = dll_pkg::SENTINEL;
                  if (head_last == dll_pkg::SENTINEL) head_first = dll_pkg::LINK_W'(e);
                  else nxt[head_last] = dll_pkg::LINK_W'(e);
                  head_last = dll_pkg::LINK_W'(e);
               end
               r.handle = 4'(e);
            end
         end
         dll_pkg::FUNC_POP_FRONT, dll_pkg::FUNC_POP_BACK: begin
            e = (func == dll_pkg::FUNC_POP_FRONT) ? int'(head_first) : int'(head_last);
            if (count == 0 || e >= dll_pkg::DEPTH) begin
               r.status = dll_pkg::ST_EMPTY;
            end else begin
               r.value = unlink(e);
               r.handle = 4'(e);
            end
         end
         dll_pkg::FUNC_REMOVE: begin
            if (int'(handle) >= dll_pkg::DEPTH || !used[handle]) begin
               r.status = dll_pkg::ST_NOT_USE;
            end else begin
               r.value = unlink(int'(handle));
               r.handle = handle;
            end
         end
         default: ;
      endcase
      r.empty = (count == 0);
      r.count = 5'(count);
      pending.push_back(r);
   endfunction

   function void check_result(logic [31:0] value, logic [3:0] handle, logic [1:0] status,
                              logic empty, logic [4:0] cnt);
      list_result_type x;
      if (pending.size() == 0) begin
         $display("%0t: result with no request outstanding: value %h handle %0d status %0d",
                  $time, value, handle, status);
         errors++;
         return;
      end
      x = pending.pop_front();
      if (value !== x.value) begin
         $display("%0t: out_value expected %h actual %h", $time, x.value, value);
         errors++;
      end
      if (handle !== x.handle) begin
         $display("%0t: out_handle expected %0d actual %0d", $time, x.handle, handle);
         errors++;
      end
      if (status !== x.status) begin
         $display("%0t: status expected %0d actual %0d", $time, x.status, status);
         errors++;
      end
      if (empty !== x.empty) begin
         $display("%0t: list_empty expected %0d actual %0d", $time, x.empty, empty);
         errors++;
      end
      if (cnt !== x.count) begin
         $display("%0t: node_count expected %0d actual %0d", $time, x.count, cnt);
         errors++;
      end
   endfunction
endclass

module tb_doubly_linked_list_manager;
   import dll_pkg::*;

   localparam int unsigned RANDOM_REQS = 1925;
   localparam int unsigned CYCLE_LIMIT = 200000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_func = '0;
   logic signed [31:0] req_value = '0;
   logic [3:0]         req_handle = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_out_value;
   logic [3:0]         rsp_out_handle;
   logic [1:0]         rsp_status;
   logic               rsp_list_empty;
   logic [4:0]         rsp_node_count;

   list_scoreboard sb;
   bit             calm = 1'b0;
   int unsigned    stall_left = 0;
   int unsigned    cycles = 0;

   doubly_linked_list_manager uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_value      (req_value),
      .req_handle     (req_handle),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_value  (rsp_out_value),
      .rsp_out_handle (rsp_out_handle),
      .rsp_status     (rsp_status),
      .rsp_list_empty (rsp_list_empty),
      .rsp_node_count (rsp_node_count)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_doubly_linked_list_manager: errors");
         $finish;
      end
   end

   // result side: check accepted results, stall in short bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_out_value, rsp_out_handle, rsp_status,
                            rsp_list_empty, rsp_node_count);
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // present one request and hold it until accepted
   task automatic send_req(input logic [2:0] f, input logic [31:0] v, input logic [3:0] h);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_func   <= f;
      req_value  <= v;
      req_handle <= h;
      do @(posedge clock); while (req_stall);
      sb.note_request(f, v, h);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending.size() != 0);
   endtask

   task automatic run_directed();
      logic [31:0] vals [4];
      vals[0] = 32'h7fff_ffff;
      vals[1] = 32'h8000_0000;
      vals[2] = 32'h0000_0000;
      vals[3] = 32'hffff_ffff;
      send_req(FUNC_POP_FRONT, 32'h0, 4'd0);
      send_req(FUNC_POP_BACK, 32'h0, 4'd0);
      send_req(FUNC_REMOVE, 32'h0, 4'd15);
      send_req(3'd5, 32'h0, 4'd0);
      send_req(3'd7, 32'hffff_ffff, 4'd15);
      // fill the pool, alternating ends
      for (int i = 0; i < DEPTH; i++)
         send_req((i % 2) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT,
                  (i < 4) ? vals[i] : $urandom, 4'(i));
      send_req(FUNC_PUSH_BACK, 32'h1234_5678, 4'd0);
      send_req(FUNC_REMOVE, 32'h0, 4'd15);
      send_req(FUNC_REMOVE, 32'h0, 4'd15);
      send_req(FUNC_POP_FRONT, 32'h0, 4'd0);
      send_req(FUNC_POP_BACK, 32'h0, 4'd0);
   endtask

   task automatic run_random(input int unsigned total);
      int unsigned done;
      int unsigned steps;
      int unsigned push_pct;
      int unsigned pick;
      bit          paused;
      logic [2:0]  f;
      logic [31:0] v;
      logic [3:0]  h;
      done = 0;
      steps = 0;
      push_pct = 50;
      paused = 1'b0;
      while (done < total) begin
         // drift between filling, draining and churning
         if (steps % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: push_pct = 75;
               1: push_pct = 25;
               default: push_pct = 50;
            endcase
         end
         steps++;
         calm = (done + 250 >= total);
         if (!paused && done >= total / 2) begin
            wait_drained();
            paused = 1'b1;
         end
         v = $urandom;
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
               0: v = 32'h7fff_ffff;
               1: v = 32'h8000_0000;
               2: v = 32'h0000_0000;
               default: v = 32'hffff_ffff;
            endcase
         end
         h = 4'($urandom_range(0, 15));
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            f = 3'($urandom_range(5, 7));
         end else if ($urandom_range(0, 99) < push_pct) begin
            f = $urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
         end else begin
            case ($urandom_range(0, 2))
               0: f = FUNC_POP_FRONT;
               1: f = FUNC_POP_BACK;
               default: begin
                  f = FUNC_REMOVE;
                  if ($urandom_range(0, 9) < 8) h = sb.pick_used_handle();
               end
            endcase
         end
         send_req(f, v, h);
         done++;
      end
   endtask

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      wait_drained();
      run_random(RANDOM_REQS);
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (sb.errors == 0)
         $display("tb_doubly_linked_list_manager: clean");
      else
         $display("tb_doubly_linked_list_manager: errors");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/dll_pkg.sv
hdl/doubly_linked_list_manager.sv
tb/sv/tb_doubly_linked_list_manager.sv
